/* design/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared codes, field widths and controller command types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int NUM_BITS = 33;
    localparam int DEN_BITS = 32;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [3:0] CMD_NONE   = 4'd0;
    localparam logic [3:0] CMD_LOAD   = 4'd1;
    localparam logic [3:0] CMD_G1SET  = 4'd2;
    localparam logic [3:0] CMD_GSTEP  = 4'd3;
    localparam logic [3:0] CMD_LCM    = 4'd4;
    localparam logic [3:0] CMD_DSTEP  = 4'd5;
    localparam logic [3:0] CMD_SCALE  = 4'd6;
    localparam logic [3:0] CMD_COMB   = 4'd7;
    localparam logic [3:0] CMD_G2SET  = 4'd8;
    localparam logic [3:0] CMD_RDSET  = 4'd9;
    localparam logic [3:0] CMD_RDSET2 = 4'd10;
    localparam logic [3:0] CMD_FINISH = 4'd11;
    localparam logic [3:0] CMD_MULX   = 4'd12;

    typedef struct packed {
        logic [3:0] cmd;
    } t_ctl;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic err;
        logic is_addsub;
    } t_sts;

endpackage

/* design/rau_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one item per transfer with a generic payload.
// ----------------------------------------------------------------------------
interface rau_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/rau_datapath.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Sign-magnitude operands, an iterative remainder gcd, a restoring divider
// and one shared multiplier, all driven by controller commands.
// ----------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
#(
    parameter int IN_WIDTH = 16
) (
    input  logic                       i_clk,
    input  t_ctl                       i_ctl,
    input  logic [1:0]                 i_action,
    input  logic [IN_WIDTH-1:0]        i_num_a,
    input  logic [IN_WIDTH-1:0]        i_den_a,
    input  logic [IN_WIDTH-1:0]        i_num_b,
    input  logic [IN_WIDTH-1:0]        i_den_b,
    output t_sts                       o_sts,
    output logic [NUM_BITS-1:0]        o_result_num,
    output logic [DEN_BITS-1:0]        o_result_den,
    output logic                       o_is_whole,
    output logic                       o_div_error
);

    localparam int MW  = IN_WIDTH;
    localparam int PW  = 2 * IN_WIDTH;
    localparam int SW  = PW + 1;
    localparam int CW  = $clog2(SW + 1);

    logic [1:0]    r_act;
    logic          r_sna, r_sda, r_snb, r_sdb;
    logic [MW-1:0] r_mna, r_mda, r_mnb, r_mdb;
    logic [SW-1:0] r_ga, r_gb;
    logic [SW-1:0] r_dq, r_dr, r_dd;
    logic [CW-1:0] r_dcnt;
    logic [SW-1:0] r_l, r_t1;
    logic [SW-1:0] r_mnum, r_mden;
    logic          r_snum, r_sden;
    logic          r_err;
    logic [1:0]    r_phase;
    logic [NUM_BITS-1:0] r_onum;
    logic [DEN_BITS-1:0] r_oden;
    logic          r_whole, r_oerr;

    logic [MW-1:0] n_mag [4];
    logic [IN_WIDTH-1:0] w_raw [4];
    logic [SW:0]   w_trial;
    logic [SW-1:0] w_mul_a, w_mul_b;
    logic [2*SW-1:0] w_prod;
    logic          s1, s2;
    logic [SW:0]   w_sum;

    assign w_raw[0] = i_num_a;
    assign w_raw[1] = i_den_a;
    assign w_raw[2] = i_num_b;
    assign w_raw[3] = i_den_b;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_mag[k] = w_raw[k][IN_WIDTH-1] ? (~w_raw[k] + 1'b1) : w_raw[k];
        end
    end

    // Restoring division step: r_dr holds the partial remainder.
    assign w_trial = {r_dr, r_dq[SW-1]} - {1'b0, r_dd};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_ctl.cmd)
            CMD_LCM: begin
                w_mul_a = r_dq;
                w_mul_b = SW'(r_mdb);
            end
            CMD_SCALE: begin
                w_mul_a = r_phase[0] ? SW'(r_mnb) : SW'(r_mna);
                w_mul_b = r_dq;
            end
            CMD_MULX: begin
                w_mul_a = r_phase[0] ? SW'(r_mda) : SW'(r_mna);
                w_mul_b = r_phase[0]
                    ? ((r_act == ACT_DIV) ? SW'(r_mnb) : SW'(r_mdb))
                    : ((r_act == ACT_DIV) ? SW'(r_mdb) : SW'(r_mnb));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        s1 = r_sna ^ r_sda;
        s2 = (r_snb ^ r_sdb) ^ (r_act == ACT_SUB);
        if (s1 == s2) begin
            w_sum = {1'b0, r_t1} + {1'b0, r_mnum};
        end else if (r_t1 >= r_mnum) begin
            w_sum = {1'b0, r_t1} - {1'b0, r_mnum};
        end else begin
            w_sum = {1'b0, r_mnum} - {1'b0, r_t1};
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LOAD: begin
                r_act <= i_action;
                r_sna <= i_num_a[IN_WIDTH-1];
                r_sda <= i_den_a[IN_WIDTH-1];
                r_snb <= i_num_b[IN_WIDTH-1];
                r_sdb <= i_den_b[IN_WIDTH-1];
                r_mna <= n_mag[0];
                r_mda <= n_mag[1];
                r_mnb <= n_mag[2];
                r_mdb <= n_mag[3];
                r_err <= (n_mag[1] == '0) || (n_mag[3] == '0)
                      || (i_action == ACT_DIV && n_mag[2] == '0);
                r_phase <= '0;
            end
            CMD_G1SET: begin
                r_ga <= SW'(r_mda);
                r_gb <= SW'(r_mdb);
                r_phase <= 2'd3;
            end
            CMD_GSTEP: begin
                r_dq   <= r_ga;
                r_dd   <= r_gb;
                r_dr   <= '0;
                r_dcnt <= CW'(SW);
            end
            CMD_DSTEP: begin
                r_dq <= {r_dq[SW-2:0], ~w_trial[SW]};
                r_dr <= w_trial[SW] ? {r_dr[SW-2:0], r_dq[SW-1]} : w_trial[SW-1:0];
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == CW'(1) && r_phase == 2'd3) begin
                    r_ga <= r_gb;
                    r_gb <= w_trial[SW] ? {r_dr[SW-2:0], r_dq[SW-1]}
                                        : w_trial[SW-1:0];
                end
            end
            CMD_RDSET: begin
                r_phase <= 2'd2;
                r_dq <= SW'(r_mda);
                r_dd <= r_ga;
                r_dr <= '0;
                r_dcnt <= CW'(SW);
            end
            CMD_LCM: begin
                r_l <= w_prod[SW-1:0];
                r_phase <= 2'd0;
                r_dq <= w_prod[SW-1:0];
                r_dd <= SW'(r_mda);
                r_dr <= '0;
                r_dcnt <= CW'(SW);
            end
            CMD_SCALE: begin
                if (r_phase[0]) begin
                    r_mnum <= w_prod[SW-1:0];
                end else begin
                    r_t1 <= w_prod[SW-1:0];
                    r_phase <= 2'd1;
                    r_dq <= r_l;
                    r_dd <= SW'(r_mdb);
                    r_dr <= '0;
                    r_dcnt <= CW'(SW);
                end
            end
            CMD_COMB: begin
                r_mnum <= w_sum[SW-1:0];
                r_snum <= (s1 == s2) ? s1 : ((r_t1 >= r_mnum) ? s1 : s2);
                r_mden <= r_l;
                r_sden <= 1'b0;
            end
            CMD_MULX: begin
                if (r_phase[0]) begin
                    r_mden <= w_prod[SW-1:0];
                    r_sden <= (r_act == ACT_DIV) ? (r_sda ^ r_snb) : (r_sda ^ r_sdb);
                end else begin
                    r_mnum <= w_prod[SW-1:0];
                    r_snum <= (r_act == ACT_DIV) ? (r_sna ^ r_sdb) : (r_sna ^ r_snb);
                    r_phase <= 2'd1;
                end
            end
            CMD_G2SET: begin
                r_ga <= r_mnum;
                r_gb <= r_mden;
                r_phase <= 2'd3;
            end
            CMD_RDSET2: begin
                if (r_phase == 2'd3) begin
                    r_phase <= 2'd0;
                    r_dq <= r_mnum;
                end else begin
                    r_mnum <= r_dq;
                    r_phase <= 2'd1;
                    r_dq <= r_mden;
                end
                r_dd <= r_ga;
                r_dr <= '0;
                r_dcnt <= CW'(SW);
            end
            CMD_FINISH: begin
                r_oerr <= r_err;
                if (r_err) begin
                    r_onum  <= '0;
                    r_oden  <= '0;
                    r_whole <= 1'b0;
                end else begin
                    r_onum  <= NUM_BITS'(r_snum ? (~r_mnum + 1'b1) : r_mnum);
                    r_oden  <= DEN_BITS'(r_sden ? (~r_dq + 1'b1) : r_dq);
                    r_whole <= !r_sden && (r_dq == SW'(1));
                end
            end
            default: begin
                r_act <= r_act;
            end
        endcase
    end

    assign o_sts.gcd_done  = (r_gb == '0);
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.err       = r_err;
    assign o_sts.is_addsub = (r_act == ACT_ADD) || (r_act == ACT_SUB);

    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_is_whole   = r_whole;
    assign o_div_error  = r_oerr;

endmodule

/* design/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences load, gcd, lcm scaling, combine or multiply, reduction and output.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_G1    = 5'd2;
    localparam logic [4:0] S_G1D   = 5'd3;
    localparam logic [4:0] S_RD    = 5'd5;
    localparam logic [4:0] S_RDW   = 5'd6;
    localparam logic [4:0] S_LCM   = 5'd7;
    localparam logic [4:0] S_LQW   = 5'd8;
    localparam logic [4:0] S_SC1   = 5'd9;
    localparam logic [4:0] S_SQW   = 5'd10;
    localparam logic [4:0] S_SC2   = 5'd11;
    localparam logic [4:0] S_COMB  = 5'd12;
    localparam logic [4:0] S_MUL1  = 5'd13;
    localparam logic [4:0] S_MUL2  = 5'd14;
    localparam logic [4:0] S_G2    = 5'd15;
    localparam logic [4:0] S_G2T   = 5'd16;
    localparam logic [4:0] S_G2D   = 5'd17;
    localparam logic [4:0] S_R1    = 5'd18;
    localparam logic [4:0] S_R1W   = 5'd19;
    localparam logic [4:0] S_R2    = 5'd20;
    localparam logic [4:0] S_R2W   = 5'd21;
    localparam logic [4:0] S_FIN   = 5'd22;
    localparam logic [4:0] S_OUT   = 5'd23;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_ctl.cmd = CMD_NONE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else if (i_sts.is_addsub) begin
                    o_ctl.cmd = CMD_G1SET;
                    n_state = S_G1;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_G1: begin
                if (i_sts.gcd_done) begin
                    o_ctl.cmd = CMD_RDSET;
                    n_state = S_RDW;
                end else begin
                    o_ctl.cmd = CMD_GSTEP;
                    n_state = S_G1D;
                end
            end
            S_G1D: begin
                if (i_sts.div_done) begin
                    n_state = S_G1;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_RD: n_state = S_RDW;
            S_RDW: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = CMD_LCM;
                    n_state = S_LQW;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_LCM: n_state = S_LQW;
            S_LQW: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = CMD_SCALE;
                    n_state = S_SQW;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_SC1: n_state = S_SQW;
            S_SQW: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = CMD_SCALE;
                    n_state = S_COMB;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_SC2: n_state = S_COMB;
            S_COMB: begin
                o_ctl.cmd = CMD_COMB;
                n_state = S_G2;
            end
            S_MUL1: begin
                o_ctl.cmd = CMD_MULX;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.cmd = CMD_MULX;
                n_state = S_G2;
            end
            S_G2: begin
                o_ctl.cmd = CMD_G2SET;
                n_state = S_G2T;
            end
            S_G2T: begin
                if (i_sts.gcd_done) begin
                    o_ctl.cmd = CMD_RDSET2;
                    n_state = S_R1W;
                end else begin
                    o_ctl.cmd = CMD_GSTEP;
                    n_state = S_G2D;
                end
            end
            S_G2D: begin
                if (i_sts.div_done) begin
                    n_state = S_G2T;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_R1: n_state = S_R1W;
            S_R1W: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = CMD_RDSET2;
                    n_state = S_R2W;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_R2: n_state = S_R2W;
            S_R2W: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_DSTEP;
                end
            end
            S_FIN: begin
                if (!r_out_valid) begin
                    o_ctl.cmd = CMD_FINISH;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* design/rational_arithmetic_unit.sv */
// An item with a zero denominator goes from the check state straight to the finish
// state; otherwise the time is set by the gcd loops, in which every remainder is
// taken by a restoring divider at one quotient bit a cycle.
// Throughput: one item at a time; the next is taken once the result is stored.
// The result register holds its item until it is taken.
// Reset is synchronous and active low and clears the controller and valid flag.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int IN_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_if.sink   i_in,
    rau_if.source o_out
);

    t_ctl w_ctl;
    t_sts w_sts;
    logic [NUM_BITS-1:0] w_num;
    logic [DEN_BITS-1:0] w_den;
    logic w_whole, w_err;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    rau_datapath #(.IN_WIDTH(IN_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_action     (i_in.data[4*IN_WIDTH+1:4*IN_WIDTH]),
        .i_num_a      (i_in.data[4*IN_WIDTH-1:3*IN_WIDTH]),
        .i_den_a      (i_in.data[3*IN_WIDTH-1:2*IN_WIDTH]),
        .i_num_b      (i_in.data[2*IN_WIDTH-1:IN_WIDTH]),
        .i_den_b      (i_in.data[IN_WIDTH-1:0]),
        .o_sts        (w_sts),
        .o_result_num (w_num),
        .o_result_den (w_den),
        .o_is_whole   (w_whole),
        .o_div_error  (w_err)
    );

    assign o_out.data = {w_num, w_den, w_whole, w_err};

endmodule
